>>> rtl/cache_set_lru_tag_store_unit_defines.svh
// Assertion macros for the cache set LRU tag store.
`ifndef CACHE_SET_LRU_TAG_STORE_UNIT_DEFINES_SVH
`define CACHE_SET_LRU_TAG_STORE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CSLRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CSLRU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CSLRU_ASSERT(lbl, prop, msg)
`define CSLRU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/cslru_pkg.sv
// Shared types, constants and microcode table of the cache set LRU tag store.
package cslru_pkg;

  localparam int WAYS_DEF     = 8;
  localparam int TAG_BITS_DEF = 20;
  localparam int STAMP_BITS   = 32;
  localparam int CFG_BITS     = 4;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 2;

  localparam logic [APB_AW-1:0]   ADDR_WAYS_IN_USE = 2'd0;
  localparam logic [CFG_BITS-1:0] WAYS_IN_USE_RST  = 4'd8;

  localparam logic OPC_LOOKUP = 1'b0;
  localparam logic OPC_INSERT = 1'b1;

  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SCAN   = 3'd1;
  localparam step_t STEP_DECIDE = 3'd2;
  localparam step_t STEP_EVPREP = 3'd3;
  localparam step_t STEP_SHIFT  = 3'd4;
  localparam step_t STEP_APPEND = 3'd5;
  localparam step_t STEP_TOUCH  = 3'd6;
  localparam step_t STEP_RESULT = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_TOUCH,
    OP_EVPREP,
    OP_SHIFT,
    OP_APPEND,
    OP_PUBLISH
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SCAN_MORE,
    C_IS_LOOKUP,
    C_NO_EVICT,
    C_SHIFT_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  hold;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic scan_more;
    logic is_lookup;
    logic no_evict;
    logic shift_more;
    logic out_busy;
  } flags_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    case (step)
      STEP_IDLE:   w = '{op: OP_LOAD,    cond: C_NO_INPUT,   hold: 1'b1, target: STEP_IDLE};
      STEP_SCAN:   w = '{op: OP_SCAN,    cond: C_SCAN_MORE,  hold: 1'b0, target: STEP_SCAN};
      STEP_DECIDE: w = '{op: OP_NONE,    cond: C_IS_LOOKUP,  hold: 1'b0, target: STEP_TOUCH};
      STEP_EVPREP: w = '{op: OP_EVPREP,  cond: C_NO_EVICT,   hold: 1'b0, target: STEP_APPEND};
      STEP_SHIFT:  w = '{op: OP_SHIFT,   cond: C_SHIFT_MORE, hold: 1'b0, target: STEP_SHIFT};
      STEP_APPEND: w = '{op: OP_APPEND,  cond: C_ALWAYS,     hold: 1'b0, target: STEP_RESULT};
      STEP_TOUCH:  w = '{op: OP_TOUCH,   cond: C_ALWAYS,     hold: 1'b0, target: STEP_RESULT};
      STEP_RESULT: w = '{op: OP_PUBLISH, cond: C_OUT_BUSY,   hold: 1'b1, target: STEP_RESULT};
      default:     w = '{op: OP_NONE,    cond: C_NEVER,      hold: 1'b0, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/cslru_in_if.sv
// Input item channel of the cache set LRU tag store.
interface cslru_in_if #(
  parameter int TAG_BITS = cslru_pkg::TAG_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [TAG_BITS-1:0]              tag;
  logic                             line_modified;
  logic [cslru_pkg::STAMP_BITS-1:0] cycle_now;

  modport source (output valid, output opcode, output tag, output line_modified,
                  output cycle_now, input ready);
  modport sink   (input valid, input opcode, input tag, input line_modified,
                  input cycle_now, output ready);
endinterface

>>> rtl/cslru_out_if.sv
// Result item channel of the cache set LRU tag store.
interface cslru_out_if #(
  parameter int TAG_BITS = cslru_pkg::TAG_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                hit;
  logic                victim_is_modified;
  logic                all_lines_modified;
  logic                evicted;
  logic [TAG_BITS-1:0] evicted_tag;

  modport source (output valid, output hit, output victim_is_modified,
                  output all_lines_modified, output evicted, output evicted_tag,
                  input ready);
  modport sink   (input valid, input hit, input victim_is_modified,
                  input all_lines_modified, input evicted, input evicted_tag,
                  output ready);
endinterface

>>> rtl/cslru_ctrl.sv
// Microcode sequencer: step counter, control word table and conditional jumps.
module cslru_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  cslru_pkg::flags_t flags_i,
  output logic              in_ready_o,
  output cslru_pkg::op_e    op_o
);

  cslru_pkg::step_t  step_q, step_d;
  cslru_pkg::uword_t uw;
  logic              cond_true;

  always_comb begin
    uw = cslru_pkg::ucode_rom(step_q);
    case (uw.cond)
      cslru_pkg::C_NEVER:      cond_true = 1'b0;
      cslru_pkg::C_ALWAYS:     cond_true = 1'b1;
      cslru_pkg::C_NO_INPUT:   cond_true = !in_valid_i;
      cslru_pkg::C_SCAN_MORE:  cond_true = flags_i.scan_more;
      cslru_pkg::C_IS_LOOKUP:  cond_true = flags_i.is_lookup;
      cslru_pkg::C_NO_EVICT:   cond_true = flags_i.no_evict;
      cslru_pkg::C_SHIFT_MORE: cond_true = flags_i.shift_more;
      cslru_pkg::C_OUT_BUSY:   cond_true = flags_i.out_busy;
      default:                 cond_true = 1'b0;
    endcase
    op_o       = (uw.hold && cond_true) ? cslru_pkg::OP_NONE : uw.op;
    in_ready_o = (uw.op == cslru_pkg::OP_LOAD);
    step_d     = cond_true ? uw.target : cslru_pkg::step_t'(step_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= cslru_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/cslru_dp.sv
// Datapath: entry registers, scan and shift pointer, victim tracking, result register.
module cslru_dp #(
  parameter int WAYS     = cslru_pkg::WAYS_DEF,
  parameter int TAG_BITS = cslru_pkg::TAG_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cslru_pkg::op_e                   op_i,
  input  logic [cslru_pkg::CFG_BITS-1:0]   ways_in_use_i,
  input  logic                             in_opcode_i,
  input  logic [TAG_BITS-1:0]              in_tag_i,
  input  logic                             in_line_modified_i,
  input  logic [cslru_pkg::STAMP_BITS-1:0] in_cycle_now_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_hit_o,
  output logic                             out_victim_is_modified_o,
  output logic                             out_all_lines_modified_o,
  output logic                             out_evicted_o,
  output logic [TAG_BITS-1:0]              out_evicted_tag_o,
  output cslru_pkg::flags_t                flags_o
);

  localparam int CW   = $clog2(WAYS + 1);
  localparam int IW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CMPW = (CW > cslru_pkg::CFG_BITS) ? CW : cslru_pkg::CFG_BITS;
  localparam int SW   = cslru_pkg::STAMP_BITS;

  logic [TAG_BITS-1:0] tag_q   [WAYS];
  logic [SW-1:0]       stamp_q [WAYS];
  logic                dirty_q [WAYS];

  logic [CW-1:0]       count_q;
  logic                out_valid_q;

  logic                opc_q;
  logic [TAG_BITS-1:0] tag_in_q;
  logic                mod_q;
  logic [SW-1:0]       now_q;
  logic                full_nz_q;
  logic [CW-1:0]       i_q;
  logic [IW-1:0]       best_q;
  logic [SW-1:0]       best_stamp_q;
  logic                best_dirty_q;
  logic [TAG_BITS-1:0] best_tag_q;
  logic                allmod_q;
  logic                found_q;
  logic [IW-1:0]       hit_idx_q;
  logic                ev_q;
  logic [TAG_BITS-1:0] evtag_q;

  logic                hit_q;
  logic                vmod_q;
  logic                allm_q;
  logic                evd_q;
  logic [TAG_BITS-1:0] evtag_out_q;

  logic [CMPW-1:0]     ways_ext;
  logic [CMPW-1:0]     cap;
  logic                full;
  logic [CW:0]         i_p1;
  logic [CW:0]         i_p2;
  logic [CW:0]         count_ext;
  logic                scan_act;
  logic                shift_act;
  logic [IW-1:0]       rd_idx;
  logic [TAG_BITS-1:0] rd_tag;
  logic [SW-1:0]       rd_stamp;
  logic                rd_dirty;
  logic [CW-1:0]       app_idx;
  logic                app_act;

  always_comb begin
    ways_ext = CMPW'(ways_in_use_i);
    if (ways_ext == '0) begin
      cap = CMPW'(1);
    end else if (ways_ext > CMPW'(WAYS)) begin
      cap = CMPW'(WAYS);
    end else begin
      cap = ways_ext;
    end
    full      = CMPW'(count_q) >= cap;
    i_p1      = {1'b0, i_q} + {{CW{1'b0}}, 1'b1};
    i_p2      = {1'b0, i_q} + (CW + 1)'(2);
    count_ext = {1'b0, count_q};
    scan_act  = i_q < count_q;
    shift_act = i_p1 < count_ext;
    rd_idx    = (op_i == cslru_pkg::OP_SHIFT) ? i_p1[IW-1:0] : i_q[IW-1:0];
    rd_tag    = tag_q[rd_idx];
    rd_stamp  = stamp_q[rd_idx];
    rd_dirty  = dirty_q[rd_idx];
    app_idx   = count_q - CW'(ev_q);
    app_act   = app_idx < CW'(WAYS);

    flags_o.scan_more  = i_p1 < count_ext;
    flags_o.is_lookup  = (opc_q == cslru_pkg::OPC_LOOKUP);
    flags_o.no_evict   = !full_nz_q;
    flags_o.shift_more = i_p2 < count_ext;
    flags_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == cslru_pkg::OP_APPEND) begin
        count_q <= app_act ? CW'(app_idx + CW'(1)) : app_idx;
      end
      if (op_i == cslru_pkg::OP_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      cslru_pkg::OP_LOAD: begin
        opc_q     <= in_opcode_i;
        tag_in_q  <= in_tag_i;
        mod_q     <= in_line_modified_i;
        now_q     <= in_cycle_now_i;
        full_nz_q <= full && (count_q != '0);
        i_q       <= '0;
        allmod_q  <= 1'b1;
        found_q   <= 1'b0;
        ev_q      <= 1'b0;
        evtag_q   <= '0;
      end
      cslru_pkg::OP_SCAN: begin
        if (scan_act) begin
          if ((i_q == '0) || (rd_stamp < best_stamp_q)) begin
            best_q       <= i_q[IW-1:0];
            best_stamp_q <= rd_stamp;
            best_dirty_q <= rd_dirty;
            best_tag_q   <= rd_tag;
          end
          if (!rd_dirty) begin
            allmod_q <= 1'b0;
          end
          if (!found_q && (rd_tag == tag_in_q)) begin
            found_q   <= 1'b1;
            hit_idx_q <= i_q[IW-1:0];
          end
          i_q <= i_p1[CW-1:0];
        end
      end
      cslru_pkg::OP_TOUCH: begin
        if (found_q) begin
          stamp_q[hit_idx_q] <= now_q;
        end
      end
      cslru_pkg::OP_EVPREP: begin
        ev_q    <= full_nz_q;
        evtag_q <= full_nz_q ? best_tag_q : '0;
        i_q     <= CW'(best_q);
      end
      cslru_pkg::OP_SHIFT: begin
        if (shift_act) begin
          tag_q[i_q[IW-1:0]]   <= rd_tag;
          stamp_q[i_q[IW-1:0]] <= rd_stamp;
          dirty_q[i_q[IW-1:0]] <= rd_dirty;
          i_q                  <= i_p1[CW-1:0];
        end
      end
      cslru_pkg::OP_APPEND: begin
        if (app_act) begin
          tag_q[app_idx[IW-1:0]]   <= tag_in_q;
          stamp_q[app_idx[IW-1:0]] <= now_q;
          dirty_q[app_idx[IW-1:0]] <= mod_q;
        end
      end
      cslru_pkg::OP_PUBLISH: begin
        hit_q       <= (opc_q == cslru_pkg::OPC_LOOKUP) && found_q;
        vmod_q      <= full_nz_q && best_dirty_q;
        allm_q      <= full_nz_q && allmod_q;
        evd_q       <= ev_q;
        evtag_out_q <= evtag_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o              = out_valid_q;
  assign out_hit_o                = hit_q;
  assign out_victim_is_modified_o = vmod_q;
  assign out_all_lines_modified_o = allm_q;
  assign out_evicted_o            = evd_q;
  assign out_evicted_tag_o        = evtag_out_q;

endmodule

>>> rtl/cache_set_lru_tag_store_unit.sv
// Top level of the cache set LRU tag store: config register, sequencer and datapath.
//
//  port     | direction | role
//  ---------+-----------+----------------------------------------------
//  in_i     | sink      | item: opcode, tag, line_modified, cycle_now
//  out_o    | source    | item: hit, victim/all-modified, evicted, tag
//  apb      | slave     | ways_in_use at byte address 0
//
//  With n lines held (at least 1), a lookup scans all n entries and an insert
//  may also evict a line: the scan reads one entry per cycle, and an eviction
//  closes the gap one entry per cycle.
//  Reset clears the line count and the sequencer; entries need no clearing.
//  A result waits in the output register; the result step stalls while that
//  register is full and the sink is not ready, and only then is the next item taken.
`include "cache_set_lru_tag_store_unit_defines.svh"
module cache_set_lru_tag_store_unit #(
  parameter int WAYS     = cslru_pkg::WAYS_DEF,
  parameter int TAG_BITS = cslru_pkg::TAG_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cslru_in_if.sink                       in_i,
  cslru_out_if.source                    out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cslru_pkg::APB_AW-1:0]   paddr,
  input  logic [cslru_pkg::APB_DW-1:0]   pwdata,
  output logic [cslru_pkg::APB_DW-1:0]   prdata,
  output logic                           pready
);

  logic [cslru_pkg::CFG_BITS-1:0] ways_q;
  cslru_pkg::op_e                 op;
  cslru_pkg::flags_t              flags;
  logic                           in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= cslru_pkg::WAYS_IN_USE_RST;
    end else if (psel && penable && pwrite && (paddr == cslru_pkg::ADDR_WAYS_IN_USE)) begin
      ways_q <= pwdata[cslru_pkg::CFG_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == cslru_pkg::ADDR_WAYS_IN_USE) ?
                  cslru_pkg::APB_DW'(ways_q) : '0;

  cslru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .flags_i    (flags),
    .in_ready_o (in_ready),
    .op_o       (op)
  );

  assign in_i.ready = in_ready;

  cslru_dp #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .op_i                     (op),
    .ways_in_use_i            (ways_q),
    .in_opcode_i              (in_i.opcode),
    .in_tag_i                 (in_i.tag),
    .in_line_modified_i       (in_i.line_modified),
    .in_cycle_now_i           (in_i.cycle_now),
    .out_ready_i              (out_o.ready),
    .out_valid_o              (out_o.valid),
    .out_hit_o                (out_o.hit),
    .out_victim_is_modified_o (out_o.victim_is_modified),
    .out_all_lines_modified_o (out_o.all_lines_modified),
    .out_evicted_o            (out_o.evicted),
    .out_evicted_tag_o        (out_o.evicted_tag),
    .flags_o                  (flags)
  );

  `CSLRU_ASSERT(a_leave_idle_after_accept, (in_i.valid && in_ready) |=> !in_ready, "item accepted but sequencer stayed idle")
  `CSLRU_ASSERT(a_valid_from_publish, $rose(out_o.valid) |-> $past(op == cslru_pkg::OP_PUBLISH), "result valid without publish step")
  `CSLRU_ASSERT_ALWAYS(a_shift_only_on_insert, (op == cslru_pkg::OP_SHIFT || op == cslru_pkg::OP_APPEND) |-> !flags.is_lookup, "entry rewrite during lookup")

endmodule

>>> bench/cache_set_lru_tag_store_unit_tb.sv
// Self-checking testbench of the cache set LRU tag store against a predictor.
module cache_set_lru_tag_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAYS          = cslru_pkg::WAYS_DEF;
  localparam int TAG_BITS      = cslru_pkg::TAG_BITS_DEF;
  localparam int STAMP_BITS    = cslru_pkg::STAMP_BITS;
  localparam int CFG_BITS      = cslru_pkg::CFG_BITS;
  localparam int APB_AW        = cslru_pkg::APB_AW;
  localparam int APB_DW        = cslru_pkg::APB_DW;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 2 * WAYS + 8;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [TAG_BITS-1:0]   TAG_MAX   = '1;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic                hit;
    logic                victim_is_modified;
    logic                all_lines_modified;
    logic                evicted;
    logic [TAG_BITS-1:0] evicted_tag;
  } set_result_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  cslru_in_if  #(.TAG_BITS(TAG_BITS)) in_if ();
  cslru_out_if #(.TAG_BITS(TAG_BITS)) out_if ();

  cache_set_lru_tag_store_unit #(
    .WAYS    (WAYS),
    .TAG_BITS(TAG_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4ns clk_i = 1'b1;
    #4ns clk_i = 1'b0;
  end

  logic [TAG_BITS-1:0]   model_tag   [WAYS];
  logic [STAMP_BITS-1:0] model_stamp [WAYS];
  logic                  model_dirty [WAYS];
  int                    model_count;
  logic [CFG_BITS-1:0]   model_ways;

  set_result_t           awaited_set_results [$];
  int                    mismatch_count = 0;
  int                    src_idle_pct   = 0;
  int                    snk_idle_pct   = 0;
  int                    hold_request   = 0;
  logic [STAMP_BITS-1:0] stamp_clock    = '0;

  function automatic set_result_t apply_to_set(input logic op, input logic [TAG_BITS-1:0] tag,
                                               input logic mdf,
                                               input logic [STAMP_BITS-1:0] now);
    set_result_t res;
    int          cap;
    int          victim;
    bit          full;
    res = '0;
    cap = int'(model_ways);
    if (cap < 1) cap = 1;
    if (cap > WAYS) cap = WAYS;
    full = (model_count >= cap) && (model_count > 0);
    victim = 0;
    for (int i = 1; i < model_count; i++) begin
      if (model_stamp[i] < model_stamp[victim]) victim = i;
    end
    if (full) begin
      res.victim_is_modified = model_dirty[victim];
      res.all_lines_modified = 1'b1;
      for (int i = 0; i < model_count; i++) begin
        if (!model_dirty[i]) res.all_lines_modified = 1'b0;
      end
    end
    if (op == cslru_pkg::OPC_LOOKUP) begin
      for (int i = 0; i < model_count; i++) begin
        if (model_tag[i] == tag) begin
          model_stamp[i] = now;
          res.hit = 1'b1;
          break;
        end
      end
    end else begin
      if (full) begin
        res.evicted     = 1'b1;
        res.evicted_tag = model_tag[victim];
        for (int i = victim; i + 1 < model_count; i++) begin
          model_tag[i]   = model_tag[i+1];
          model_stamp[i] = model_stamp[i+1];
          model_dirty[i] = model_dirty[i+1];
        end
        model_count--;
      end
      if (model_count < WAYS) begin
        model_tag[model_count]   = tag;
        model_stamp[model_count] = now;
        model_dirty[model_count] = mdf;
        model_count++;
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result();
    set_result_t exp_res;
    if (awaited_set_results.size() == 0) begin
      $error("result item with no expected result pending");
      mismatch_count++;
      return;
    end
    exp_res = awaited_set_results.pop_front();
    check_field("hit", 32'(exp_res.hit), 32'(out_if.hit));
    check_field("victim_is_modified", 32'(exp_res.victim_is_modified),
                32'(out_if.victim_is_modified));
    check_field("all_lines_modified", 32'(exp_res.all_lines_modified),
                32'(out_if.all_lines_modified));
    check_field("evicted", 32'(exp_res.evicted), 32'(out_if.evicted));
    check_field("evicted_tag", 32'(exp_res.evicted_tag), 32'(out_if.evicted_tag));
  endfunction

  task automatic send_item(input logic op, input logic [TAG_BITS-1:0] tag, input logic mdf,
                           input logic [STAMP_BITS-1:0] now);
    set_result_t exp_res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.tag           <= tag;
    in_if.line_modified <= mdf;
    in_if.cycle_now     <= now;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    exp_res = apply_to_set(op, tag, mdf, now);
    awaited_set_results = {awaited_set_results, exp_res};
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (awaited_set_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_ways_in_use(input logic [CFG_BITS-1:0] ways);
    logic [APB_DW-1:0] data;
    settle();
    data = $urandom();
    data[CFG_BITS-1:0] = ways;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cslru_pkg::ADDR_WAYS_IN_USE;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_ways = ways;
  endtask

  task automatic send_random_item();
    int unsigned         pick;
    logic                op;
    logic                mdf;
    logic [TAG_BITS-1:0] tag;
    pick = $urandom_range(99);
    tag  = TAG_BITS'($urandom());
    mdf  = 1'($urandom_range(1));
    op   = cslru_pkg::OPC_INSERT;
    if (pick < 45 && model_count > 0) begin
      op  = cslru_pkg::OPC_LOOKUP;
      tag = model_tag[$urandom_range(model_count - 1)];
    end else if (pick < 55) begin
      op = cslru_pkg::OPC_LOOKUP;
    end else if (pick < 62 && model_count > 0) begin
      tag = model_tag[$urandom_range(model_count - 1)];
    end
    case ($urandom_range(9))
      0:       send_item(op, tag, mdf, $urandom());
      1:       send_item(op, tag, mdf, stamp_clock);
      default: begin
        stamp_clock = stamp_clock + $urandom_range(1, 4);
        send_item(op, tag, mdf, stamp_clock);
      end
    endcase
  endtask

  task automatic test_basic_lookup_insert();
    send_item(cslru_pkg::OPC_LOOKUP, '0, 1'b0, '0);
    send_item(cslru_pkg::OPC_INSERT, '0, 1'b0, '0);
    send_item(cslru_pkg::OPC_INSERT, TAG_MAX, 1'b1, STAMP_MAX);
    send_item(cslru_pkg::OPC_LOOKUP, TAG_MAX, 1'b0, 32'd5);
    send_item(cslru_pkg::OPC_LOOKUP, 20'h12345, 1'b1, 32'd6);
    send_item(cslru_pkg::OPC_INSERT, '0, 1'b1, 32'd10);
    send_item(cslru_pkg::OPC_LOOKUP, '0, 1'b0, 32'd20);
  endtask

  task automatic test_capacity_and_eviction();
    set_ways_in_use(4'd2);
    send_item(cslru_pkg::OPC_LOOKUP, '0, 1'b0, 32'd21);
    send_item(cslru_pkg::OPC_INSERT, 20'hAAAAA, 1'b1, 32'd21);
    send_item(cslru_pkg::OPC_INSERT, 20'h55555, 1'b0, 32'd10);
    set_ways_in_use(4'd0);
    send_item(cslru_pkg::OPC_INSERT, 20'h5A5A5, 1'b0, 32'd40);
    send_item(cslru_pkg::OPC_LOOKUP, 20'h5A5A5, 1'b0, 32'd41);
    set_ways_in_use(4'd15);
    for (int i = 0; i < 6; i++) begin
      send_item(cslru_pkg::OPC_INSERT, TAG_BITS'(20'hF0000 + i), 1'b1, STAMP_BITS'(50 + i));
    end
    send_item(cslru_pkg::OPC_LOOKUP, 20'hF0003, 1'b0, 32'd60);
    send_item(cslru_pkg::OPC_INSERT, 20'h0F0F0, 1'b1, 32'd61);
    send_item(cslru_pkg::OPC_INSERT, 20'h0F0F1, 1'b0, 32'd61);
    set_ways_in_use(4'd1);
    send_item(cslru_pkg::OPC_INSERT, 20'h00001, 1'b1, 32'd70);
    send_item(cslru_pkg::OPC_LOOKUP, 20'h00001, 1'b0, 32'd71);
    stamp_clock = 32'd100;
  endtask

  task automatic test_random_phase(input int n, input int src_pct, input int snk_pct,
                                   input logic [4*CFG_BITS-1:0] ways_list);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int k = 0; k < 4; k++) begin
      set_ways_in_use(ways_list[CFG_BITS*k +: CFG_BITS]);
      repeat (n / 4) send_random_item();
    end
  endtask

  task automatic test_backpressure();
    set_ways_in_use(4'd8);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request++;
    repeat (30) send_random_item();
    settle();
    repeat (20) send_random_item();
  endtask

  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_result();
      if (hold_seen != hold_request) begin
        hold_seen = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    in_if.valid         <= 1'b0;
    in_if.opcode        <= cslru_pkg::OPC_LOOKUP;
    in_if.tag           <= '0;
    in_if.line_modified <= 1'b0;
    in_if.cycle_now     <= '0;
    model_count = 0;
    model_ways  = cslru_pkg::WAYS_IN_USE_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 37;
    snk_idle_pct = 80;
    test_basic_lookup_insert();
    test_capacity_and_eviction();
    test_random_phase(140, 37, 80, {4'd0, 4'd4, 4'd1, 4'd8});
    stamp_clock = 32'hFFFF_FF00;
    test_random_phase(140, 80, 37, {4'd8, 4'd6, 4'd2, 4'd15});
    test_random_phase(140, 0, 0, {4'd8, 4'd1, 4'd7, 4'd3});
    test_backpressure();
    settle();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
